### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vprc_pkg.sv
// ----------------------------------------------------------------------------
// vprc_pkg
// Types, constants and helpers of the polar/rectangular vector converter.
// ----------------------------------------------------------------------------
`default_nettype none

package vprc_pkg;

    localparam int W          = 32;
    localparam int ANGW       = 19;
    localparam int ZW         = 34;
    localparam int VW         = 36;
    localparam int SQRT_STEPS = 32;

    localparam logic [2:0] CMD_RECT  = 3'd0;
    localparam logic [2:0] CMD_POLAR = 3'd1;
    localparam logic [2:0] CMD_ADD   = 3'd2;
    localparam logic [2:0] CMD_SUB   = 3'd3;
    localparam logic [2:0] CMD_SCALE = 3'd4;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] ANGLE_MAX   = 34'sd205887;
    localparam logic signed [31:0]   GAIN_Q30    = 32'sd652032874;
    localparam logic signed [31:0]   DEG2RAD_Q32 = 32'sd74961321;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic signed [W-1:0] cx;
        logic signed [W-1:0] cy;
        logic signed [W-1:0] n;
    } cmd_word_t;

    typedef struct packed {
        logic signed [W-1:0] rx;
        logic signed [W-1:0] ry;
        logic                polar;
        logic                bad;
    } side_t;

    typedef struct packed {
        logic signed [63:0]   x;
        logic signed [63:0]   y;
        logic signed [ZW-1:0] z;
        side_t                side;
    } rot_t;

    typedef struct packed {
        logic signed [W-1:0] rx;
        logic signed [W-1:0] ry;
        logic [63:0]         sq;
        logic                bad;
        logic                zero;
    } vside_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        vside_t               side;
    } vec_t;

    typedef struct packed {
        logic [63:0]           n;
        logic [33:0]           rem;
        logic [W-1:0]          root;
        logic signed [W-1:0]   rx;
        logic signed [W-1:0]   ry;
        logic signed [ANGW-1:0] ang;
        logic                  bad;
    } sqr_t;

    function automatic logic signed [W-1:0] sat32(input logic signed [63:0] v);
        logic signed [W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[W-1:0];
        return r;
    endfunction

    // floor(atan(2^-i) * 2^30)
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        unique case (i)
            0:  r = 34'sd843314856;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043836;
            3:  r = 34'sd133525158;
            4:  r = 34'sd67021686;
            5:  r = 34'sd33543515;
            6:  r = 34'sd16775850;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194282;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            24: r = 34'sd63;
            25: r = 34'sd31;
            26: r = 34'sd15;
            27: r = 34'sd7;
            28: r = 34'sd3;
            29: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/vprc_in_if.sv
// ----------------------------------------------------------------------------
// vprc_in_if
// Command channel: valid/ready with command and operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface vprc_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        cmd;
    logic signed [31:0] first_a;
    logic signed [31:0] first_b;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] scale_factor;

    modport source (output valid, cmd, first_a, first_b, second_x, second_y, scale_factor,
                    input ready);
    modport sink (input valid, cmd, first_a, first_b, second_x, second_y, scale_factor,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/vprc_out_if.sv
// ----------------------------------------------------------------------------
// vprc_out_if
// Result channel: valid/ready with vector, length and angle.
// ----------------------------------------------------------------------------
`default_nettype none

interface vprc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic [31:0]        magnitude;
    logic signed [18:0] angle_rad;
    logic               bad_cmd;

    modport source (output valid, res_x, res_y, magnitude, angle_rad, bad_cmd, input ready);
    modport sink (input valid, res_x, res_y, magnitude, angle_rad, bad_cmd, output ready);
endinterface

`default_nettype wire

### hw/rtl/vprc_front.sv
// ----------------------------------------------------------------------------
// vprc_front
// Seven-stage front end: rectangular results, degree reduction, radian
// conversion, gain scaling and quarter-turn pre-rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module vprc_front
    import vprc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  cmd_word_t in_d,
    output logic      out_valid,
    input  logic      out_ready,
    output rot_t      out_d
);

    localparam logic [39:0] FULL  = 40'(64'd360 << FRAC_BITS);
    localparam logic [39:0] HALF  = FULL >> 1;
    localparam logic [31:0] RECIP = 32'((64'd1 << 48) / (64'd360 << FRAC_BITS));
    localparam logic signed [63:0] RND_S = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] RND_Z = 64'sd1 <<< (FRAC_BITS + 1);

    logic en1, en2, en3, en4, en5, en6, en7;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    // stage 1
    logic [2:0]          f1_cmd_reg;
    logic signed [W-1:0] f1_a_reg, f1_sx_reg, f1_sy_reg;
    logic [W-1:0]        f1_u_reg;
    logic                f1_neg_reg;
    logic signed [63:0]  f1_pa_reg, f1_pb_reg;
    logic signed [W-1:0] f1_sx_next, f1_sy_next;
    // stage 2
    side_t               f2_side_reg, f2_side_next;
    logic signed [W-1:0] f2_a_reg;
    logic [W-1:0]        f2_u_reg;
    logic                f2_neg_reg;
    logic [15:0]         f2_q_reg;
    // stage 3
    side_t               f3_side_reg;
    logic signed [W-1:0] f3_a_reg;
    logic                f3_neg_reg;
    logic [39:0]         f3_rem_reg;
    // stage 4
    side_t               f4_side_reg;
    logic signed [W-1:0] f4_a_reg;
    logic                f4_neg_reg;
    logic [39:0]         f4_rem_reg;
    // stage 5
    side_t               f5_side_reg;
    logic signed [W-1:0] f5_a_reg;
    logic signed [ZW-1:0] f5_r_reg;
    logic signed [40:0]  rs, fs, r_next;
    // stage 6
    side_t               f6_side_reg;
    logic signed [63:0]  f6_x_reg;
    logic signed [ZW-1:0] f6_z_reg;
    logic signed [63:0]  zp;
    // stage 7
    rot_t                f7_reg, f7_next;

    assign en7      = !v7_reg || out_ready;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    always_comb
    begin
        unique case (in_d.cmd)
            CMD_RECT:
            begin
                f1_sx_next = in_d.a;
                f1_sy_next = in_d.b;
            end
            CMD_ADD:
            begin
                f1_sx_next = sat32(64'(in_d.a) + 64'(in_d.cx));
                f1_sy_next = sat32(64'(in_d.b) + 64'(in_d.cy));
            end
            CMD_SUB:
            begin
                f1_sx_next = sat32(64'(in_d.a) - 64'(in_d.cx));
                f1_sy_next = sat32(64'(in_d.b) - 64'(in_d.cy));
            end
            default:
            begin
                f1_sx_next = '0;
                f1_sy_next = '0;
            end
        endcase
    end

    always_comb
    begin
        f2_side_next = '0;
        unique case (f1_cmd_reg)
            CMD_RECT, CMD_ADD, CMD_SUB:
            begin
                f2_side_next.rx = f1_sx_reg;
                f2_side_next.ry = f1_sy_reg;
            end
            CMD_POLAR:
                f2_side_next.polar = 1'b1;
            CMD_SCALE:
            begin
                f2_side_next.rx = sat32((f1_pa_reg + RND_S) >>> FRAC_BITS);
                f2_side_next.ry = sat32((f1_pb_reg + RND_S) >>> FRAC_BITS);
            end
            default:
                f2_side_next.bad = 1'b1;
        endcase
    end

    always_comb
    begin
        rs = $signed({1'b0, f4_rem_reg});
        fs = $signed({1'b0, FULL});
        if (f4_neg_reg && f4_rem_reg != '0)
            r_next = (f4_rem_reg <= HALF) ? -rs : fs - rs;
        else
            r_next = (f4_rem_reg >= HALF) ? rs - fs : rs;
    end

    assign zp = 64'(f5_r_reg) * 64'(DEG2RAD_Q32);

    always_comb
    begin
        f7_next      = '0;
        f7_next.side = f6_side_reg;
        if (f6_z_reg > HALF_PI_Q30)
        begin
            f7_next.y = f6_x_reg;
            f7_next.z = f6_z_reg - HALF_PI_Q30;
        end
        else if (f6_z_reg < -HALF_PI_Q30)
        begin
            f7_next.y = -f6_x_reg;
            f7_next.z = f6_z_reg + HALF_PI_Q30;
        end
        else
        begin
            f7_next.x = f6_x_reg;
            f7_next.z = f6_z_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            f1_cmd_reg <= in_d.cmd;
            f1_a_reg   <= in_d.a;
            f1_u_reg   <= in_d.b[W-1] ? W'(-in_d.b) : W'(in_d.b);
            f1_neg_reg <= in_d.b[W-1];
            f1_pa_reg  <= 64'(in_d.a) * 64'(in_d.n);
            f1_pb_reg  <= 64'(in_d.b) * 64'(in_d.n);
            f1_sx_reg  <= f1_sx_next;
            f1_sy_reg  <= f1_sy_next;
        end
        if (en2)
        begin
            f2_side_reg <= f2_side_next;
            f2_a_reg    <= f1_a_reg;
            f2_u_reg    <= f1_u_reg;
            f2_neg_reg  <= f1_neg_reg;
            f2_q_reg    <= 16'((64'(f1_u_reg) * 64'(RECIP)) >> 48);
        end
        if (en3)
        begin
            f3_side_reg <= f2_side_reg;
            f3_a_reg    <= f2_a_reg;
            f3_neg_reg  <= f2_neg_reg;
            f3_rem_reg  <= 40'(f2_u_reg) - 40'(f2_q_reg) * FULL;
        end
        if (en4)
        begin
            f4_side_reg <= f3_side_reg;
            f4_a_reg    <= f3_a_reg;
            f4_neg_reg  <= f3_neg_reg;
            f4_rem_reg  <= (f3_rem_reg >= FULL) ? f3_rem_reg - FULL : f3_rem_reg;
        end
        if (en5)
        begin
            f5_side_reg <= f4_side_reg;
            f5_a_reg    <= f4_a_reg;
            f5_r_reg    <= ZW'(r_next);
        end
        if (en6)
        begin
            f6_side_reg <= f5_side_reg;
            f6_x_reg    <= 64'(f5_a_reg) * 64'(GAIN_Q30);
            f6_z_reg    <= ZW'((zp + RND_Z) >>> (FRAC_BITS + 2));
        end
        if (en7)
            f7_reg <= f7_next;
    end

    assign out_valid = v7_reg;
    assign out_d     = f7_reg;

endmodule

`default_nettype wire

### hw/rtl/vprc_rot_cell.sv
// ----------------------------------------------------------------------------
// vprc_rot_cell
// One rotation-mode CORDIC micro-rotation with a registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module vprc_rot_cell
    import vprc_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rot_t d,
    output logic out_valid,
    input  logic out_ready,
    output rot_t q
);

    logic               en;
    logic               valid_reg;
    rot_t               data_reg, data_next;
    logic signed [63:0] dx, dy;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        dx        = d.y >>> IDX;
        dy        = d.x >>> IDX;
        data_next = d;
        if (d.z >= 0)
        begin
            data_next.x = d.x - dx;
            data_next.y = d.y + dy;
            data_next.z = d.z - atan_q30(IDX);
        end
        else
        begin
            data_next.x = d.x + dx;
            data_next.y = d.y - dy;
            data_next.z = d.z + atan_q30(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign q         = data_reg;

endmodule

`default_nettype wire

### hw/rtl/vprc_vec_cell.sv
// ----------------------------------------------------------------------------
// vprc_vec_cell
// One vectoring-mode CORDIC micro-rotation with a registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module vprc_vec_cell
    import vprc_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  vec_t d,
    output logic out_valid,
    input  logic out_ready,
    output vec_t q
);

    logic                 en;
    logic                 valid_reg;
    vec_t                 data_reg, data_next;
    logic signed [VW-1:0] dx, dy;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        dx        = d.y >>> IDX;
        dy        = d.x >>> IDX;
        data_next = d;
        if (d.y >= 0)
        begin
            data_next.x = d.x + dx;
            data_next.y = d.y - dy;
            data_next.z = d.z + atan_q30(IDX);
        end
        else
        begin
            data_next.x = d.x - dx;
            data_next.y = d.y + dy;
            data_next.z = d.z - atan_q30(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign q         = data_reg;

endmodule

`default_nettype wire

### hw/rtl/vprc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vprc_sqrt_cell
// One restoring square-root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
`default_nettype none

module vprc_sqrt_cell
    import vprc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sqr_t d,
    output logic out_valid,
    input  logic out_ready,
    output sqr_t q
);

    logic        en;
    logic        valid_reg;
    sqr_t        data_reg, data_next;
    logic [35:0] rem4, trial;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        rem4        = {d.rem, d.n[63:62]};
        trial       = {2'b00, d.root, 2'b01};
        data_next   = d;
        data_next.n = {d.n[61:0], 2'b00};
        if (rem4 >= trial)
        begin
            data_next.rem  = 34'(rem4 - trial);
            data_next.root = {d.root[W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = 34'(rem4);
            data_next.root = {d.root[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign q         = data_reg;

endmodule

`default_nettype wire

### hw/rtl/vector_polar_rect_convert.sv
// Throughput: one word per cycle while the output is not stalled; every stage
// is a registered cell with its own valid, and bubbles close up under output
// backpressure.
// Reset: asynchronous, clears the valid flags only; the data is not reset.
// ----------------------------------------------------------------------------
// vector_polar_rect_convert
// Vector converter: front end, rotation CORDIC row, vectoring CORDIC row and
// square-root row for the length.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vector_polar_rect_convert
    import vprc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    vprc_in_if.sink    req,
    vprc_out_if.source rsp
);

    cmd_word_t cw;

    rot_t rot_d [CORDIC_STAGES+1];
    logic rot_v [CORDIC_STAGES+1];
    logic rot_r [CORDIC_STAGES+1];

    vec_t vec_d [CORDIC_STAGES+1];
    logic vec_v [CORDIC_STAGES+1];
    logic vec_r [CORDIC_STAGES+1];

    sqr_t sq_d [SQRT_STEPS+1];
    logic sq_v [SQRT_STEPS+1];
    logic sq_r [SQRT_STEPS+1];

    logic                 j_en, s_en, o_en;
    logic                 j_valid_reg, s_valid_reg, o_valid_reg;
    logic signed [W-1:0]  j_rx_reg, j_ry_reg, j_rx_next, j_ry_next;
    logic                 j_bad_reg;
    logic signed [VW-1:0] s_x_reg, s_y_reg, s_x_next, s_y_next, xe, ye;
    logic signed [ZW-1:0] s_z_reg, s_z_next;
    logic [63:0]          s_xx_reg, s_yy_reg;
    logic signed [W-1:0]  s_rx_reg, s_ry_reg;
    logic                 s_bad_reg, s_zero_reg;
    logic signed [ZW-1:0] zr;
    logic signed [ANGW-1:0] ang_next;
    logic signed [W-1:0]  o_rx_reg, o_ry_reg;
    logic [W-1:0]         o_mag_reg, mag_next;
    logic signed [ANGW-1:0] o_ang_reg;
    logic                 o_bad_reg;

    assign cw.cmd = req.cmd;
    assign cw.a   = req.first_a;
    assign cw.b   = req.first_b;
    assign cw.cx  = req.second_x;
    assign cw.cy  = req.second_y;
    assign cw.n   = req.scale_factor;

    vprc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_d      (cw),
        .out_valid (rot_v[0]),
        .out_ready (rot_r[0]),
        .out_d     (rot_d[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        vprc_rot_cell #(.IDX(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rot_v[i]),
            .in_ready  (rot_r[i]),
            .d         (rot_d[i]),
            .out_valid (rot_v[i+1]),
            .out_ready (rot_r[i+1]),
            .q         (rot_d[i+1])
        );
    end

    // polar words take the rotated vector, the rest their precomputed one
    assign j_en                 = !j_valid_reg || s_en;
    assign rot_r[CORDIC_STAGES] = j_en;

    always_comb
    begin
        if (rot_d[CORDIC_STAGES].side.polar)
        begin
            j_rx_next = sat32((rot_d[CORDIC_STAGES].x + 64'sd536870912) >>> 30);
            j_ry_next = sat32((rot_d[CORDIC_STAGES].y + 64'sd536870912) >>> 30);
        end
        else
        begin
            j_rx_next = rot_d[CORDIC_STAGES].side.rx;
            j_ry_next = rot_d[CORDIC_STAGES].side.ry;
        end
    end

    // squares and vectoring pre-rotation into the right half plane
    assign s_en = !s_valid_reg || vec_r[0];

    always_comb
    begin
        xe = VW'(j_rx_reg);
        ye = VW'(j_ry_reg);
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                s_x_next = ye;
                s_y_next = -xe;
                s_z_next = HALF_PI_Q30;
            end
            else
            begin
                s_x_next = -ye;
                s_y_next = xe;
                s_z_next = -HALF_PI_Q30;
            end
        end
        else
        begin
            s_x_next = xe;
            s_y_next = ye;
            s_z_next = '0;
        end
    end

    assign vec_v[0]         = s_valid_reg;
    assign vec_d[0].x       = s_x_reg;
    assign vec_d[0].y       = s_y_reg;
    assign vec_d[0].z       = s_z_reg;
    assign vec_d[0].side.rx   = s_rx_reg;
    assign vec_d[0].side.ry   = s_ry_reg;
    assign vec_d[0].side.sq   = s_xx_reg + s_yy_reg;
    assign vec_d[0].side.bad  = s_bad_reg;
    assign vec_d[0].side.zero = s_zero_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_vec
        vprc_vec_cell #(.IDX(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vec_v[i]),
            .in_ready  (vec_r[i]),
            .d         (vec_d[i]),
            .out_valid (vec_v[i+1]),
            .out_ready (vec_r[i+1]),
            .q         (vec_d[i+1])
        );
    end

    // round the angle to Q3.16 and clamp
    always_comb
    begin
        zr = (vec_d[CORDIC_STAGES].z + 34'sd8192) >>> 14;
        if (vec_d[CORDIC_STAGES].side.zero)
            ang_next = '0;
        else if (zr > ANGLE_MAX)
            ang_next = ANGW'(ANGLE_MAX);
        else if (zr < -ANGLE_MAX)
            ang_next = ANGW'(-ANGLE_MAX);
        else
            ang_next = ANGW'(zr);
    end

    assign vec_r[CORDIC_STAGES] = sq_r[0];
    assign sq_v[0]              = vec_v[CORDIC_STAGES];
    assign sq_d[0].n            = vec_d[CORDIC_STAGES].side.sq;
    assign sq_d[0].rem          = '0;
    assign sq_d[0].root         = '0;
    assign sq_d[0].rx           = vec_d[CORDIC_STAGES].side.rx;
    assign sq_d[0].ry           = vec_d[CORDIC_STAGES].side.ry;
    assign sq_d[0].ang          = ang_next;
    assign sq_d[0].bad          = vec_d[CORDIC_STAGES].side.bad;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        vprc_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[i]),
            .in_ready  (sq_r[i]),
            .d         (sq_d[i]),
            .out_valid (sq_v[i+1]),
            .out_ready (sq_r[i+1]),
            .q         (sq_d[i+1])
        );
    end

    // round the root to nearest
    assign o_en              = !o_valid_reg || rsp.ready;
    assign sq_r[SQRT_STEPS]  = o_en;
    assign mag_next = (34'(sq_d[SQRT_STEPS].root) < sq_d[SQRT_STEPS].rem)
                    ? sq_d[SQRT_STEPS].root + 1'b1 : sq_d[SQRT_STEPS].root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (j_en) j_valid_reg <= rot_v[CORDIC_STAGES];
            if (s_en) s_valid_reg <= j_valid_reg;
            if (o_en) o_valid_reg <= sq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (j_en)
        begin
            j_rx_reg  <= j_rx_next;
            j_ry_reg  <= j_ry_next;
            j_bad_reg <= rot_d[CORDIC_STAGES].side.bad;
        end
        if (s_en)
        begin
            s_x_reg    <= s_x_next;
            s_y_reg    <= s_y_next;
            s_z_reg    <= s_z_next;
            s_xx_reg   <= 64'(64'(j_rx_reg) * 64'(j_rx_reg));
            s_yy_reg   <= 64'(64'(j_ry_reg) * 64'(j_ry_reg));
            s_rx_reg   <= j_rx_reg;
            s_ry_reg   <= j_ry_reg;
            s_bad_reg  <= j_bad_reg;
            s_zero_reg <= (j_rx_reg == '0) && (j_ry_reg == '0);
        end
        if (o_en)
        begin
            o_rx_reg  <= sq_d[SQRT_STEPS].rx;
            o_ry_reg  <= sq_d[SQRT_STEPS].ry;
            o_mag_reg <= mag_next;
            o_ang_reg <= sq_d[SQRT_STEPS].ang;
            o_bad_reg <= sq_d[SQRT_STEPS].bad;
        end
    end

    assign rsp.valid     = o_valid_reg;
    assign rsp.res_x     = o_rx_reg;
    assign rsp.res_y     = o_ry_reg;
    assign rsp.magnitude = o_mag_reg;
    assign rsp.angle_rad = o_ang_reg;
    assign rsp.bad_cmd   = o_bad_reg;

    `ASSERT_IMPLIES(a_bad_zero, clk, rst_n, rsp.valid && rsp.bad_cmd, rsp.res_x == 0 && rsp.res_y == 0 && rsp.magnitude == 0 && rsp.angle_rad == 0, "bad command word not zeroed")
    `ASSERT_IMPLIES(a_zero_vec, clk, rst_n, rsp.valid && rsp.res_x == 0 && rsp.res_y == 0, rsp.magnitude == 0 && rsp.angle_rad == 0, "zero vector with nonzero length or angle")
    `ASSERT_IMPLIES(a_ang_range, clk, rst_n, rsp.valid, rsp.angle_rad <= 19'sd205887 && rsp.angle_rad >= -19'sd205887, "angle out of range")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.magnitude) && $stable(rsp.angle_rad), "stalled result word changed")

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Vector converter testbench
// Drives command words through the request channel and compares each result
// word against an internal predictor. A table of directed commands comes
// first, followed by random commands with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import vprc_pkg::*;

    localparam int  STAGES     = 16;
    localparam int  FRAC       = 16;
    localparam int  N_RANDOM   = 925;
    localparam int  IDLE_LIMIT = 3000;
    localparam int  DRAIN_WAIT = 200;
    localparam int  LONG_HOLD  = 400;
    localparam logic [2:0] CMD_BAD5 = 3'd5;
    localparam logic [2:0] CMD_BAD6 = 3'd6;
    localparam logic [2:0] CMD_BAD7 = 3'd7;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint ANG_MAX = 64'sd205887;
    localparam longint GAIN    = 64'sd652032874;
    localparam longint DEG2RAD = 64'sd74961321;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic [31:0]        mag;
        logic signed [18:0] ang;
        logic               bad;
    } vector_word_t;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] n;
        bit                 known;
        vector_word_t       want;
    } cmd_row_t;

    logic clk;
    logic rst_n;
    vprc_in_if  req_ch();
    vprc_out_if rsp_ch();

    vector_polar_rect_convert i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    vector_word_t pending_vectors[$];
    int           errors;
    int           results_seen;
    int           idle_cycles;
    bit           long_hold_done;

    const longint atan_tab[32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1, 0, 0
    };

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned nearest_root(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned rem;
        res  = 0;
        bitv = 64'd1 << 62;
        rem  = n;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        if (n - res * res > res)
            res++;
        return res;
    endfunction

    function automatic longint atan2_q16(input longint xi, input longint yi);
        longint x, y, z, t, dx, dy;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI;
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
        end
        z = (z + (64'sd1 <<< 13)) >>> 14;
        if (z > ANG_MAX)
            z = ANG_MAX;
        if (z < -ANG_MAX)
            z = -ANG_MAX;
        return z;
    endfunction

    function automatic void rotate_polar(input longint mag, input longint deg,
                                         output longint ox, output longint oy);
        longint full, r, z, x, y, t, dx, dy;
        full = 64'sd360 <<< FRAC;
        r = deg % full;
        if (r < 0)
            r += full;
        if (r >= full / 2)
            r -= full;
        z = (r * DEG2RAD + (64'sd1 <<< (FRAC + 1))) >>> (FRAC + 2);
        x = mag * GAIN;
        y = 0;
        if (z > HALF_PI)
        begin
            t = x;
            x = -y;
            y = t;
            z -= HALF_PI;
        end
        else if (z < -HALF_PI)
        begin
            t = x;
            x = y;
            y = -t;
            z += HALF_PI;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        ox = clamp32((x + (64'sd1 <<< 29)) >>> 30);
        oy = clamp32((y + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function automatic longint scaled(input longint a, input longint n);
        return clamp32((a * n + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic vector_word_t convert_vector(input cmd_row_t c);
        vector_word_t w;
        longint a, b, x, y;
        longint unsigned sq;
        a = c.a;
        b = c.b;
        x = 0;
        y = 0;
        w.bad = 1'b0;
        case (c.cmd)
            CMD_RECT:
            begin
                x = a;
                y = b;
            end
            CMD_POLAR: rotate_polar(a, b, x, y);
            CMD_ADD:
            begin
                x = clamp32(a + longint'(c.cx));
                y = clamp32(b + longint'(c.cy));
            end
            CMD_SUB:
            begin
                x = clamp32(a - longint'(c.cx));
                y = clamp32(b - longint'(c.cy));
            end
            CMD_SCALE:
            begin
                x = scaled(a, c.n);
                y = scaled(b, c.n);
            end
            default: w.bad = 1'b1;
        endcase
        sq    = longint'(x * x) + longint'(y * y);
        w.rx  = x[31:0];
        w.ry  = y[31:0];
        w.mag = nearest_root(sq);
        w.ang = atan2_q16(x, y);
        return w;
    endfunction

    function automatic cmd_row_t make_row(input logic [2:0] cmd,
                                          input logic signed [31:0] a,
                                          input logic signed [31:0] b,
                                          input logic signed [31:0] cx,
                                          input logic signed [31:0] cy,
                                          input logic signed [31:0] n);
        cmd_row_t r;
        r.cmd   = cmd;
        r.a     = a;
        r.b     = b;
        r.cx    = cx;
        r.cy    = cy;
        r.n     = n;
        r.known = 1'b0;
        r.want  = '{0, 0, 0, 0, 0};
        return r;
    endfunction

    function automatic cmd_row_t known_row(input cmd_row_t r, input vector_word_t w);
        cmd_row_t k;
        k       = r;
        k.known = 1'b1;
        k.want  = w;
        return k;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? MAXV : MINV;
            1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            2: return $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_row_t random_row();
        logic [2:0] cmd;
        if ($urandom_range(0, 19) == 0)
            cmd = 3'($urandom_range(CMD_BAD5, CMD_BAD7));
        else
            cmd = 3'($urandom_range(CMD_RECT, CMD_SCALE));
        if (cmd == CMD_SCALE && $urandom_range(0, 1))
            return make_row(cmd, pick_value(), pick_value(), pick_value(), pick_value(),
                            $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000);
        return make_row(cmd, pick_value(), pick_value(), pick_value(), pick_value(),
                        pick_value());
    endfunction

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch on word %0d: %s got %0d want %0d", results_seen, field, got, want);
        errors++;
    endtask

    task automatic send_word(input cmd_row_t c, input int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= c.cmd;
        req_ch.first_a      <= c.a;
        req_ch.first_b      <= c.b;
        req_ch.second_x     <= c.cx;
        req_ch.second_y     <= c.cy;
        req_ch.scale_factor <= c.n;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_vectors.push_back(c.known ? c.want : convert_vector(c));
    endtask

    initial
    begin
        cmd_row_t     rows[$];
        vector_word_t zero_w;
        vector_word_t bad_w;
        zero_w = '{0, 0, 0, 0, 1'b0};
        bad_w  = '{0, 0, 0, 0, 1'b1};
        errors = 0;
        rst_n  = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_RECT;
        req_ch.first_a      = '0;
        req_ch.first_b      = '0;
        req_ch.second_x     = '0;
        req_ch.second_y     = '0;
        req_ch.scale_factor = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(known_row(make_row(CMD_RECT, 0, 0, 0, 0, 0), zero_w));
        rows.push_back(make_row(CMD_RECT, ONE, 0, 0, 0, 0));
        rows.push_back(make_row(CMD_RECT, -ONE, 0, 0, 0, 0));
        rows.push_back(make_row(CMD_RECT, 0, -ONE, 0, 0, 0));
        rows.push_back(make_row(CMD_RECT, MAXV, MAXV, 0, 0, 0));
        rows.push_back(make_row(CMD_RECT, MINV, MINV, 0, 0, 0));
        rows.push_back(make_row(CMD_RECT, MINV, MAXV, 0, 0, 0));
        rows.push_back(make_row(CMD_ADD, MAXV, MINV, ONE, -ONE, 0));
        rows.push_back(make_row(CMD_ADD, ONE, ONE, -ONE, -ONE, 0));
        rows.push_back(make_row(CMD_SUB, MINV, MAXV, ONE, -ONE, 0));
        rows.push_back(make_row(CMD_SUB, 3 * ONE, -ONE, ONE, ONE, 0));
        rows.push_back(make_row(CMD_SCALE, MAXV, MINV, 0, 0, MAXV));
        rows.push_back(make_row(CMD_SCALE, 3 * ONE, -2 * ONE, 0, 0, -ONE / 2));
        rows.push_back(make_row(CMD_SCALE, 5, -5, 0, 0, 32'sh00008000));
        rows.push_back(make_row(CMD_POLAR, ONE, 45 * ONE, 0, 0, 0));
        rows.push_back(make_row(CMD_POLAR, ONE, 0, 0, 0, 0));
        rows.push_back(make_row(CMD_POLAR, 2 * ONE, -180 * ONE, 0, 0, 0));
        rows.push_back(make_row(CMD_POLAR, 2 * ONE, 360 * ONE, 0, 0, 0));
        rows.push_back(make_row(CMD_POLAR, -ONE, 135 * ONE, 0, 0, 0));
        rows.push_back(make_row(CMD_POLAR, MAXV, MINV, 0, 0, 0));
        rows.push_back(make_row(CMD_POLAR, MINV, MAXV, 0, 0, 0));
        rows.push_back(known_row(make_row(CMD_BAD5, ONE, ONE, ONE, ONE, ONE), bad_w));
        rows.push_back(known_row(make_row(CMD_BAD6, MAXV, MINV, 0, 0, 0), bad_w));
        rows.push_back(known_row(make_row(CMD_BAD7, -1, -1, -1, -1, -1), bad_w));

        foreach (rows[i])
            send_word(rows[i], $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                req_ch.valid <= 1'b0;
                wait (pending_vectors.size() == 0);
                @(posedge clk);
            end
            if ((i / 100) % 3 == 1)
                send_word(random_row(), 0);
            else
                send_word(random_row(), $urandom_range(0, 12));
        end
        req_ch.valid <= 1'b0;

        wait (pending_vectors.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        int stall;
        vector_word_t want;
        results_seen   = 0;
        long_hold_done = 1'b0;
        rsp_ch.ready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && results_seen == 60)
            begin
                stall = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if ((results_seen / 100) % 3 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 12);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            if (pending_vectors.size() == 0)
                report("unexpected word", 1, 0);
            else
            begin
                want = pending_vectors.pop_front();
                if (rsp_ch.res_x !== want.rx)
                    report("res_x", rsp_ch.res_x, want.rx);
                if (rsp_ch.res_y !== want.ry)
                    report("res_y", rsp_ch.res_y, want.ry);
                if (rsp_ch.magnitude !== want.mag)
                    report("magnitude", rsp_ch.magnitude, want.mag);
                if (rsp_ch.angle_rad !== want.ang)
                    report("angle_rad", rsp_ch.angle_rad, want.ang);
                if (rsp_ch.bad_cmd !== want.bad)
                    report("bad_cmd", rsp_ch.bad_cmd, want.bad);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/vprc_pkg.sv
hw/rtl/vprc_in_if.sv
hw/rtl/vprc_out_if.sv
hw/rtl/vprc_front.sv
hw/rtl/vprc_rot_cell.sv
hw/rtl/vprc_vec_cell.sv
hw/rtl/vprc_sqrt_cell.sv
hw/rtl/vector_polar_rect_convert.sv
sim/testbench.sv
